[hdl/shp_pkg.sv]
// ----------------------------------------------------------------------------
// SHA-256 stream hasher package
// Types, constants and round functions shared by the hasher modules.
// ----------------------------------------------------------------------------
package shp_pkg;

   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       end_of_message;
   } req_item_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_item_type;

   typedef enum logic [1:0] {
      OP_BYTE,
      OP_END,
      OP_BYTE_END
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data_byte;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_LOAD,
      ST_RND,
      ST_ADD,
      ST_OUT
   } state_type;

   typedef struct packed {
      state_type  state;
      logic [5:0] rnd;
   } core_status_type;

   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic [5:0] LEN_POS  = 6'd56;

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] INIT_H [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
   endfunction

endpackage

[hdl/shp_chan_if.sv]
// ----------------------------------------------------------------------------
// Stream channel
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface shp_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[hdl/shp_front.sv]
// ----------------------------------------------------------------------------
// Hasher front end
// Accepts input items, classifies them and drops items that carry nothing.
// ----------------------------------------------------------------------------
module shp_front (
   input  logic       clock,
   input  logic       reset,
   shp_chan_if.sink   req,
   shp_chan_if.source que
);
   import shp_pkg::*;

   logic         ent_valid_ff, ent_valid_in;
   entry_type    ent_ff, ent_in;
   req_item_type item;

   assign item        = req.payload;
   assign req.ready   = !ent_valid_ff || que.ready;
   assign que.valid   = ent_valid_ff;
   assign que.payload = ent_ff;

   always_comb begin
      ent_valid_in = ent_valid_ff && !que.ready;
      ent_in       = ent_ff;
      if (req.valid && req.ready) begin
         ent_valid_in      = item.has_byte || item.end_of_message;
         ent_in.data_byte  = item.data_byte;
         priority if (item.has_byte && item.end_of_message) begin
            ent_in.op = OP_BYTE_END;
         end else if (item.has_byte) begin
            ent_in.op = OP_BYTE;
         end else begin
            ent_in.op = OP_END;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_valid_ff <= 1'b0;
      end else begin
         ent_valid_ff <= ent_valid_in;
      end
      ent_ff <= ent_in;
   end
endmodule

[hdl/shp_fifo.sv]
// ----------------------------------------------------------------------------
// Hasher queue
// Small first-in first-out queue between the front end and the core.
// ----------------------------------------------------------------------------
module shp_fifo #(
   parameter int Depth = shp_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   shp_chan_if.sink   wr,
   shp_chan_if.source rd
);
   import shp_pkg::*;

   localparam int PtrW = $clog2(Depth);
   localparam int CntW = $clog2(Depth + 1);

   entry_type         mem [Depth];
   logic [PtrW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0]   level_ff, level_in;
   logic              push, pop;

   assign wr.ready   = level_ff != CntW'(Depth);
   assign rd.valid   = level_ff != '0;
   assign rd.payload = mem[rd_ptr_ff];
   assign push       = wr.valid && wr.ready;
   assign pop        = rd.valid && rd.ready;

   always_comb begin
      level_in = level_ff;
      unique case ({push, pop})
         2'b10:   level_in = level_ff + CntW'(1);
         2'b01:   level_in = level_ff - CntW'(1);
         default: level_in = level_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         level_ff <= level_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
         end
      end
      if (push) begin
         mem[wr_ptr_ff] <= wr.payload;
      end
   end
endmodule

[hdl/shp_core.sv]
// ----------------------------------------------------------------------------
// Hasher core
// Block buffer, padding, 64-round compression and digest read-out.
// ----------------------------------------------------------------------------
module shp_core (
   input  logic                     clock,
   input  logic                     reset,
   shp_chan_if.sink                 que,
   shp_chan_if.source               rsp,
   output shp_pkg::core_status_type status
);
   import shp_pkg::*;

   state_type     state_ff, state_in;
   logic [31:0]   h_ff [8];
   logic [31:0]   h_in [8];
   logic [31:0]   v_ff [8];
   logic [31:0]   v_in [8];
   logic [31:0]   w_ff [16];
   logic [31:0]   w_in [16];
   logic [63:0]   len_ff, len_in;
   logic [5:0]    rnd_ff, rnd_in;
   logic [2:0]    idx_ff, idx_in;
   logic          pend_ff, pend_in;
   logic          extra_ff, extra_in;
   logic          final_ff, final_in;
   logic [5:0]    pos;
   logic [1:0]    lane;
   logic [31:0]   t1, t2, w_new;
   entry_type     ent;
   rsp_item_type  out_item;

   assign pos  = len_ff[8:3];
   assign lane = ~pos[1:0];
   assign ent  = que.payload;

   assign t1 = v_ff[7] + big_sigma1(v_ff[4]) + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
             + ROUND_K[rnd_ff] + w_ff[0];
   assign t2 = big_sigma0(v_ff[0])
             + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   assign w_new = small_sigma1(w_ff[14]) + w_ff[9] + small_sigma0(w_ff[1]) + w_ff[0];

   assign que.ready = state_ff == ST_IDLE;
   assign rsp.valid = state_ff == ST_OUT;
   assign out_item.digest_word = h_ff[idx_ff];
   assign out_item.word_index  = idx_ff;
   assign out_item.last_word   = idx_ff == 3'd7;
   assign rsp.payload = out_item;
   assign status.state = state_ff;
   assign status.rnd   = rnd_ff;

   always_comb begin
      state_in = state_ff;
      h_in     = h_ff;
      v_in     = v_ff;
      w_in     = w_ff;
      len_in   = len_ff;
      rnd_in   = rnd_ff;
      idx_in   = idx_ff;
      pend_in  = pend_ff;
      extra_in = extra_ff;
      final_in = final_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (que.valid) begin
               if (ent.op != OP_END) begin
                  w_in[pos[5:2]][{lane, 3'b000} +: 8] = ent.data_byte;
                  len_in = len_ff + 64'd8;
                  if (pos == 6'd63) begin
                     pend_in  = ent.op == OP_BYTE_END;
                     state_in = ST_LOAD;
                  end else if (ent.op == OP_BYTE_END) begin
                     state_in = ST_PAD;
                  end
               end else begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            // Bytes before the fill position are kept, the marker goes at it,
            // and everything after it is cleared.
            for (int j = 0; j < 16; j++) begin
               for (int l = 0; l < 4; l++) begin
                  if (6'(4 * j + l) == pos) begin
                     w_in[j][8 * (3 - l) +: 8] = PAD_BYTE;
                  end else if (6'(4 * j + l) > pos) begin
                     w_in[j][8 * (3 - l) +: 8] = 8'd0;
                  end
               end
            end
            if (pos >= LEN_POS) begin
               extra_in = 1'b1;
            end else begin
               w_in[14] = len_ff[63:32];
               w_in[15] = len_ff[31:0];
               final_in = 1'b1;
            end
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            v_in     = h_ff;
            rnd_in   = '0;
            state_in = ST_RND;
         end
         ST_RND: begin
            v_in[0] = t1 + t2;
            v_in[1] = v_ff[0];
            v_in[2] = v_ff[1];
            v_in[3] = v_ff[2];
            v_in[4] = v_ff[3] + t1;
            v_in[5] = v_ff[4];
            v_in[6] = v_ff[5];
            v_in[7] = v_ff[6];
            for (int i = 0; i < 15; i++) begin
               w_in[i] = w_ff[i + 1];
            end
            w_in[15] = w_new;
            rnd_in   = rnd_ff + 6'd1;
            if (rnd_ff == 6'd63) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            for (int i = 0; i < 8; i++) begin
               h_in[i] = h_ff[i] + v_ff[i];
            end
            priority if (final_ff) begin
               idx_in   = '0;
               state_in = ST_OUT;
            end else if (extra_ff) begin
               // The length did not fit: a further block of zeros and length.
               for (int i = 0; i < 14; i++) begin
                  w_in[i] = '0;
               end
               w_in[14] = len_ff[63:32];
               w_in[15] = len_ff[31:0];
               extra_in = 1'b0;
               final_in = 1'b1;
               state_in = ST_LOAD;
            end else if (pend_ff) begin
               pend_in  = 1'b0;
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            if (rsp.ready) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  h_in     = INIT_H;
                  len_in   = '0;
                  final_in = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         h_ff     <= INIT_H;
         len_ff   <= '0;
         rnd_ff   <= '0;
         idx_ff   <= '0;
         pend_ff  <= 1'b0;
         extra_ff <= 1'b0;
         final_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         h_ff     <= h_in;
         len_ff   <= len_in;
         rnd_ff   <= rnd_in;
         idx_ff   <= idx_in;
         pend_ff  <= pend_in;
         extra_ff <= extra_in;
         final_ff <= final_in;
      end
      v_ff <= v_in;
      w_ff <= w_in;
   end
endmodule

[hdl/sha256_stream_hasher.sv]
// A byte that fills a block starts a compression (load, 64 rounds, chaining
// add); other bytes are only stored in the core's block buffer.
// A closing item costs one or two compressions plus a padding step, then
// eight digest transfers, one per cycle while the sink is ready.
// Throughput: the single round unit blocks input while busy; else one byte per cycle.
// Reset is synchronous and returns the chaining words and bit count to start.
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Byte-wide message input, digest as eight 32-bit words.
// ----------------------------------------------------------------------------
module sha256_stream_hasher #(
   parameter int QueueDepth = shp_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   shp_chan_if.sink   req,
   shp_chan_if.source rsp
);
   import shp_pkg::*;

   core_status_type status;

   shp_chan_if #(.payload_type(entry_type)) q_in ();
   shp_chan_if #(.payload_type(entry_type)) q_out ();

   shp_front u_front (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .que   (q_in)
   );

   shp_fifo #(.Depth(QueueDepth)) u_fifo (
      .clock (clock),
      .reset (reset),
      .wr    (q_in),
      .rd    (q_out)
   );

   shp_core u_core (
      .clock  (clock),
      .reset  (reset),
      .que    (q_out),
      .rsp    (rsp),
      .status (status)
   );

`ifndef SYNTH
   a_last_word: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.payload.last_word == (rsp.payload.word_index == 3'd7)))
      else $error("last word flag does not match word index");

   a_rnd_idle: assert property (@(posedge clock) disable iff (reset)
      (status.rnd != 6'd0) |-> (status.state == ST_RND || status.state == ST_ADD
                                || status.state == ST_OUT || status.state == ST_IDLE
                                || status.state == ST_PAD || status.state == ST_LOAD))
      else $error("round counter in unexpected state");

   a_digest_done: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.ready && rsp.payload.last_word) |=> !rsp.valid)
      else $error("digest continued after last word");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp.valid)
      else $error("result valid straight after reset");
`endif
endmodule

[test/tb_sha256_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 hasher checker
// Watches both channels, runs its own SHA-256 on every accepted byte and
// compares each digest word transfer with the oldest predicted word.
// ----------------------------------------------------------------------------
module tb_sha256_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  shp_pkg::req_item_type req_payload,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  shp_pkg::rsp_item_type rsp_payload,
   output int                   fail_count,
   output int                   words_pending
);
   import shp_pkg::*;

   logic [31:0] hash_state [8];
   logic [7:0]  msg_block [64];
   logic [63:0] msg_bits;
   rsp_item_type digest_queue [$];

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic compress();
      logic [31:0] w [16];
      logic [31:0] v [8];
      logic [31:0] wi, t1, t2, x15, x2;
      for (int i = 0; i < 16; i++)
         w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
      for (int i = 0; i < 8; i++) v[i] = hash_state[i];
      for (int i = 0; i < 64; i++) begin
         if (i < 16) begin
            wi = w[i];
         end else begin
            x15 = w[(i - 15) & 15];
            x2  = w[(i - 2) & 15];
            wi = w[i & 15] + (rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3))
                 + w[(i - 7) & 15] + (rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10));
            w[i & 15] = wi;
         end
         t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
              + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + wi;
         t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
              + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_state[i] += v[i];
   endtask

   task automatic restart_message();
      for (int i = 0; i < 8; i++) hash_state[i] = INIT_H[i];
      for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
      msg_bits = 64'd0;
   endtask

   task automatic absorb_item(input req_item_type it);
      int fill;
      rsp_item_type word;
      if (it.has_byte) begin
         fill = int'(msg_bits[8:3]);
         msg_block[fill] = it.data_byte;
         msg_bits += 64'd8;
         if (fill == 63) compress();
      end
      if (!it.end_of_message) return;
      fill = int'(msg_bits[8:3]);
      msg_block[fill] = PAD_BYTE;
      for (int i = fill + 1; i < 64; i++) msg_block[i] = 8'h00;
      if (fill >= int'(LEN_POS)) begin
         compress();
         for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
      end
      for (int i = 0; i < 8; i++) msg_block[63 - i] = msg_bits[8*i +: 8];
      compress();
      for (int i = 0; i < 8; i++) begin
         word.digest_word = hash_state[i];
         word.word_index  = 3'(i);
         word.last_word   = (i == 7);
         digest_queue.push_back(word);
      end
      restart_message();
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         restart_message();
         digest_queue.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (digest_queue.size() == 0) begin
               $display("%0t: unexpected digest word %h", $time, rsp_payload);
               fail_count++;
            end else begin
               want = digest_queue.pop_front();
               if (rsp_payload.digest_word !== want.digest_word
                   || rsp_payload.word_index !== want.word_index
                   || rsp_payload.last_word !== want.last_word) begin
                  $display("%0t: digest mismatch, expected %h/%0d/%b, got %h/%0d/%b",
                           $time, want.digest_word, want.word_index, want.last_word,
                           rsp_payload.digest_word, rsp_payload.word_index,
                           rsp_payload.last_word);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) absorb_item(req_payload);
      end
      words_pending <= digest_queue.size();
   end

   initial begin
      fail_count = 0;
      words_pending = 0;
   end
endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 hasher testbench
// Sends directed and random byte messages in bursts, stalls the digest side
// and lets the checker compare every digest word.
// ----------------------------------------------------------------------------
module tb_top;
   import shp_pkg::*;

   logic clock;
   logic reset;
   int   fail_count;
   int   words_pending;
   int   items_sent;
   int   burst_left;
   int   stall_phase;

   shp_chan_if #(.payload_type(req_item_type)) req_if ();
   shp_chan_if #(.payload_type(rsp_item_type)) rsp_if ();

   sha256_stream_hasher dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if.sink),
      .rsp   (rsp_if.source)
   );

   tb_sha256_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_if.valid),
      .req_ready     (req_if.ready),
      .req_payload   (req_if.payload),
      .rsp_valid     (rsp_if.valid),
      .rsp_ready     (rsp_if.ready),
      .rsp_payload   (rsp_if.payload),
      .fail_count    (fail_count),
      .words_pending (words_pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // The receiver stalls at random, with a stall-free stretch at the start of each period.
   always @(negedge clock) begin
      if (reset) begin
         stall_phase <= 0;
         rsp_if.ready <= 1'b0;
      end else begin
         stall_phase <= stall_phase + 1;
         if ((stall_phase % 400) < 120) rsp_if.ready <= 1'b1;
         else rsp_if.ready <= ($urandom_range(0, 3) != 0);
      end
   end

   // Sends one item, keeping valid high across a burst.
   task automatic send_item(input logic [7:0] b, input logic hb, input logic eom);
      req_item_type it;
      it.data_byte = b;
      it.has_byte = hb;
      it.end_of_message = eom;
      if (burst_left == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_if.valid <= 1'b1;
      req_if.payload <= it;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
      if (hb || eom) items_sent++;
   endtask

   task automatic send_message(input int len, input logic merge_end);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 9) == 0) send_item(8'($urandom), 1'b0, 1'b0);
         send_item(8'($urandom), 1'b1, merge_end && (i == len - 1));
      end
      if (!merge_end || len == 0) send_item(8'($urandom), 1'b0, 1'b1);
   endtask

   initial begin
      reset = 1'b1;
      items_sent = 0;
      burst_left = 0;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty message, field extremes, byte with end, padding boundaries.
      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'hff, 1'b0, 1'b0);
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'hff, 1'b1, 1'b1);
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h63, 1'b1, 1'b0);
      send_item(8'h00, 1'b0, 1'b1);
      send_message(56, 1'b0);
      send_message(63, 1'b1);

      // Random short messages.
      while (items_sent < 150) begin
         send_message($urandom_range(0, 12), 1'($urandom_range(0, 1)));
      end
      req_if.valid <= 1'b0;

      while (words_pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("simulation failed");
      $finish;
   end
endmodule
